>>> design/ksda_pkg.sv
// shared types and constants for the key scan debounce / autorepeat unit
// no dependencies; imported by every module of the block
package ksda_pkg;

  localparam int MUX_COUNT_DEF        = 3;
  localparam int CHANNELS_PER_MUX_DEF = 8;

  localparam int TIME_W    = 32;
  localparam int CHAN_W    = 3;
  localparam int RAW_W     = 3;
  localparam int CFG_W     = 16;
  localparam int MAP_W     = 64;
  localparam int MAP_REGS  = 3;
  localparam int CHAR_W    = 8;
  localparam int KEYNUM_W  = 5;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_REP_INITIAL  = 3'd1,
    REG_REP_INTERVAL = 3'd2,
    REG_MAP_MUX0     = 3'd3,
    REG_MAP_MUX1     = 3'd4,
    REG_MAP_MUX2     = 3'd5
  } cfg_reg_t;

  // what one lane found for the sampled key
  typedef struct packed {
    logic                emit;
    logic [CHAR_W-1:0]   key_char;
    logic [KEYNUM_W-1:0] key_number;
  } lane_res_t;

endpackage

>>> design/ksda_lane.sv
// one debounce / typematic lane: per-channel key state of one multiplexer
// depends on ksda_pkg
module ksda_lane #(
  parameter int LANE             = 0,
  parameter int CHANNELS_PER_MUX = ksda_pkg::CHANNELS_PER_MUX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic [ksda_pkg::CHAN_W-1:0]   channel,
  input  logic [ksda_pkg::TIME_W-1:0]   scan_time_ms,
  input  logic                          pressed,
  input  logic [ksda_pkg::CFG_W-1:0]    settle_ms,
  input  logic [ksda_pkg::CFG_W-1:0]    first_delay_ms,
  input  logic [ksda_pkg::CFG_W-1:0]    repeat_gap_ms,
  input  logic [ksda_pkg::CHAR_W-1:0]   map_byte,
  output ksda_pkg::lane_res_t           res
);
  import ksda_pkg::*;

  localparam int CH_W = (CHANNELS_PER_MUX > 1) ? $clog2(CHANNELS_PER_MUX) : 1;
  localparam logic [7:0] KEY_BASE = 8'(LANE * CHANNELS_PER_MUX);

  // per-key state; the previous stable state always equals the stored
  // stable state at the start of a sample, so it needs no storage of its own
  logic              raw_seen_r  [CHANNELS_PER_MUX];
  logic [TIME_W-1:0] change_r    [CHANNELS_PER_MUX];
  logic              stable_r    [CHANNELS_PER_MUX];
  logic [TIME_W-1:0] next_send_r [CHANNELS_PER_MUX];

  logic [7:0]        ch_ext;
  logic [CH_W-1:0]   ch_idx;
  logic              seen;
  logic              stable_old;
  logic              stable_nxt;
  logic              raw_seen_nxt;
  logic [TIME_W-1:0] change_nxt;
  logic [TIME_W-1:0] next_send_nxt;
  logic [TIME_W-1:0] since_change;
  logic [TIME_W-1:0] since_send;
  logic              debounced;
  logic              repeat_due;
  logic              char_ok;
  logic              emit;

  assign ch_ext = {5'b0, channel};
  assign ch_idx = ch_ext[CH_W-1:0];

  // debounce and repeat decision for the sampled key
  always_comb begin
    seen          = raw_seen_r[ch_idx];
    stable_old    = stable_r[ch_idx];
    since_change  = scan_time_ms - change_r[ch_idx];
    since_send    = scan_time_ms - next_send_r[ch_idx];
    debounced     = since_change >= {16'b0, settle_ms};
    repeat_due    = !since_send[TIME_W-1] && (since_send >= {16'b0, repeat_gap_ms});
    char_ok       = map_byte != '0;
    raw_seen_nxt  = seen;
    change_nxt    = change_r[ch_idx];
    stable_nxt    = stable_old;
    next_send_nxt = next_send_r[ch_idx];
    emit          = 1'b0;
    if (pressed != seen) begin
      raw_seen_nxt = pressed;
      change_nxt   = scan_time_ms;
    end else if (debounced) begin
      stable_nxt = pressed;
    end
    if (!stable_old && stable_nxt) begin
      if (char_ok) begin
        emit          = 1'b1;
        next_send_nxt = scan_time_ms + {16'b0, first_delay_ms};
      end
    end else if (stable_nxt) begin
      if (repeat_due && char_ok) begin
        emit          = 1'b1;
        next_send_nxt = scan_time_ms;
      end
    end
  end

  assign res.emit       = emit;
  assign res.key_char   = map_byte;
  assign res.key_number = 5'(KEY_BASE + ch_ext);

  // state write-back on an accepted sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS_PER_MUX; i++) begin
        raw_seen_r[i]  <= 1'b1;
        change_r[i]    <= '0;
        stable_r[i]    <= 1'b0;
        next_send_r[i] <= '0;
      end
    end else if (upd) begin
      raw_seen_r[ch_idx]  <= raw_seen_nxt;
      change_r[ch_idx]    <= change_nxt;
      stable_r[ch_idx]    <= stable_nxt;
      next_send_r[ch_idx] <= next_send_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a character only goes out for a stably held key with a nonzero map byte
  a_emit_held: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && emit) |-> (stable_nxt && char_ok))
    else $error("lane emitted for a key that is not stably pressed");
`endif

endmodule

>>> design/ksda_merge.sv
// merging stage: collects lane results of one sample and sends them in mux order
// depends on ksda_pkg
module ksda_merge #(
  parameter int MUX_COUNT = ksda_pkg::MUX_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  logic                             sample_ok,
  input  ksda_pkg::lane_res_t              res [MUX_COUNT],
  output logic                             load_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ksda_pkg::CHAR_W-1:0]      out_char,
  output logic [ksda_pkg::KEYNUM_W-1:0]    out_number,
  output logic                             out_last
);
  import ksda_pkg::*;

  localparam int SEL_W = (MUX_COUNT > 1) ? $clog2(MUX_COUNT) : 1;

  logic [MUX_COUNT-1:0] mask_r, mask_nxt;
  lane_res_t            batch_r [MUX_COUNT];
  logic                 ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0]    ochar_r;
  logic [KEYNUM_W-1:0]  onum_r;
  logic                 olast_r;

  logic                 take;
  logic                 pop;
  logic [SEL_W-1:0]     sel;
  logic [MUX_COUNT-1:0] rem;
  logic [MUX_COUNT-1:0] load_mask;

  // lowest pending lane goes first
  always_comb begin
    sel = '0;
    for (int i = MUX_COUNT - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = SEL_W'(i);
    end
    for (int i = 0; i < MUX_COUNT; i++) begin
      load_mask[i] = res[i].emit && sample_ok;
    end
  end

  assign take       = !ovalid_r || out_ready;
  assign pop        = take && (mask_r != '0);
  assign rem        = mask_r & ~({{(MUX_COUNT-1){1'b0}}, 1'b1} << sel);
  assign load_ready = (mask_r == '0) || (pop && (rem == '0));

  // pending mask and output register
  always_comb begin
    mask_nxt   = mask_r;
    ovalid_nxt = ovalid_r;
    if (pop) mask_nxt = rem;
    if (load) mask_nxt = load_mask;
    if (take) ovalid_nxt = mask_r != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      mask_r   <= mask_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MUX_COUNT; i++) batch_r[i] <= res[i];
    end
    if (pop) begin
      ochar_r <= batch_r[sel].key_char;
      onum_r  <= batch_r[sel].key_number;
      olast_r <= rem == '0;
    end
  end

  assign out_valid  = ovalid_r;
  assign out_char   = ochar_r;
  assign out_number = onum_r;
  assign out_last   = olast_r;

`ifndef NO_ASSERTIONS
  // a word that is not the last of its run leaves more words pending
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !olast_r) |-> (mask_r != '0))
    else $error("non-last word without pending results");
  // the rest of a run follows without a gap once a word is taken
  a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && out_ready && !olast_r) |=> ovalid_r)
    else $error("gap inside a run of results");
  // a new sample is never loaded over pending results
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ((mask_r == '0) || (pop && (rem == '0))))
    else $error("sample loaded over pending results");
`endif

endmodule

>>> design/key_scan_debounce_autorepeat_unit.sv
// key scanner with debounce and typematic repeat, one lane per multiplexer
// a sample's results are held in the merge stage, then registered one by one into the output word
// throughput: one sample per cycle while no result words are pending; otherwise the input
// waits until the pending words (up to MUX_COUNT) pass the single output port, which out_tready can stall
// reset (rst_n, synchronous): key state, configuration registers and merge control return to defaults
// depends on ksda_pkg, ksda_lane, ksda_merge
module key_scan_debounce_autorepeat_unit #(
  parameter int MUX_COUNT        = ksda_pkg::MUX_COUNT_DEF,
  parameter int CHANNELS_PER_MUX = ksda_pkg::CHANNELS_PER_MUX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,   // scan_time_ms, channel, raw_levels
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,  // key_char, key_number
  output logic                              out_tlast,  // last_of_run
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ksda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ksda_pkg::MAP_W-1:0]        cfg_data
);
  import ksda_pkg::*;

  logic [CFG_W-1:0]    debounce_r;
  logic [CFG_W-1:0]    rep_initial_r;
  logic [CFG_W-1:0]    rep_interval_r;
  logic [MAP_W-1:0]    char_map_r [MAP_REGS];

  logic [TIME_W-1:0]   scan_time;
  logic [CHAN_W-1:0]   channel;
  logic [RAW_W-1:0]    raw_levels;
  logic                accept;
  logic                sample_ok;
  logic                merge_ready;
  lane_res_t           res [MUX_COUNT];
  logic [CHAR_W-1:0]   out_char;
  logic [KEYNUM_W-1:0] out_number;

  assign scan_time  = in_tdata[31:0];
  assign channel    = in_tdata[34:32];
  assign raw_levels = in_tdata[37:35];

  assign sample_ok = {2'b0, channel} < 5'(CHANNELS_PER_MUX);
  assign in_tready = merge_ready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= 16'd20;
      rep_initial_r  <= 16'd500;
      rep_interval_r <= 16'd100;
      for (int i = 0; i < MAP_REGS; i++) char_map_r[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:     debounce_r     <= cfg_data[CFG_W-1:0];
        REG_REP_INITIAL:  rep_initial_r  <= cfg_data[CFG_W-1:0];
        REG_REP_INTERVAL: rep_interval_r <= cfg_data[CFG_W-1:0];
        REG_MAP_MUX0:     char_map_r[0]  <= cfg_data;
        REG_MAP_MUX1:     char_map_r[1]  <= cfg_data;
        REG_MAP_MUX2:     char_map_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // one lane per multiplexer; muxes without a raw bit read pressed, without a map read zero
  for (genvar m = 0; m < MUX_COUNT; m++) begin : g_lane
    logic              pressed;
    logic [CHAR_W-1:0] map_byte;
    if (m < RAW_W) begin : g_raw
      assign pressed = !raw_levels[m];
    end else begin : g_noraw
      assign pressed = 1'b1;
    end
    if (m < MAP_REGS) begin : g_map
      assign map_byte = char_map_r[m][{channel, 3'b0} +: CHAR_W];
    end else begin : g_nomap
      assign map_byte = '0;
    end
    ksda_lane #(
      .LANE             (m),
      .CHANNELS_PER_MUX (CHANNELS_PER_MUX)
    ) u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .upd            (accept && sample_ok),
      .channel        (channel),
      .scan_time_ms   (scan_time),
      .pressed        (pressed),
      .settle_ms      (debounce_r),
      .first_delay_ms (rep_initial_r),
      .repeat_gap_ms  (rep_interval_r),
      .map_byte       (map_byte),
      .res            (res[m])
    );
  end

  // merge lane results into the output stream
  ksda_merge #(
    .MUX_COUNT (MUX_COUNT)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .sample_ok  (sample_ok),
    .res        (res),
    .load_ready (merge_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_char),
    .out_number (out_number),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'b0, out_number, out_char};

endmodule

>>> tb/key_scan_debounce_autorepeat_unit_tb.sv
// self-checking testbench for key_scan_debounce_autorepeat_unit: scan words in,
// key character words out, checked against an in-bench debounce/repeat predictor
// depends on ksda_pkg and the unit's RTL only
`timescale 1ns / 1ps

module key_scan_debounce_autorepeat_unit_tb;
  import ksda_pkg::*;

  localparam int KEYS        = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LATENCY_PAD = 8;

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_HI = 3'd7;

  typedef struct packed {
    logic [CHAR_W-1:0]   key_char;
    logic [KEYNUM_W-1:0] key_number;
    logic                last_of_run;
  } key_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [39:0]          in_tdata;   // scan_time_ms, channel, raw_levels
  logic                 out_tvalid;
  logic                 out_tready;
  logic [15:0]          out_tdata;  // key_char, key_number
  logic                 out_tlast;  // last_of_run
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MAP_W-1:0]     cfg_data;

  key_scan_debounce_autorepeat_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor copy of registers and per-key state
  logic [15:0] debounce_cfg;
  logic [15:0] initial_cfg;
  logic [15:0] interval_cfg;
  logic [63:0] char_rows [MAP_REGS];
  logic        seen_pressed [KEYS];
  logic [31:0] changed_at [KEYS];
  logic        stable_now [KEYS];
  logic        stable_prev [KEYS];
  logic [31:0] due_at [KEYS];

  key_word_t   key_words_due [$];
  key_word_t   want;
  logic [31:0] scan_ms;
  int          send_idle_pct;
  int          ready_stall_pct;
  int          mismatches;
  int          words_checked;
  int          scans_sent;
  int          reg_writes;
  int          cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  // compare each accepted key word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (key_words_due.size() == 0) begin
        $error("unexpected key word: key_char %0h key_number %0d last %0b",
               out_tdata[7:0], out_tdata[12:8], out_tlast);
        mismatches++;
      end else begin
        want = key_words_due.pop_front();
        words_checked++;
        if (out_tdata[7:0] !== want.key_char) begin
          $error("key_char: expected %0h, got %0h", want.key_char, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[12:8] !== want.key_number) begin
          $error("key_number: expected %0d, got %0d", want.key_number, out_tdata[12:8]);
          mismatches++;
        end
        if (out_tlast !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, out_tlast);
          mismatches++;
        end
      end
    end
  end

  function automatic void reset_keys();
    debounce_cfg = 16'd20;
    initial_cfg  = 16'd500;
    interval_cfg = 16'd100;
    for (int m = 0; m < MAP_REGS; m++) char_rows[m] = '0;
    for (int k = 0; k < KEYS; k++) begin
      seen_pressed[k] = 1'b1;
      changed_at[k]   = '0;
      stable_now[k]   = 1'b0;
      stable_prev[k]  = 1'b0;
      due_at[k]       = '0;
    end
  endfunction

  // debounce and typematic repeat for the three keys on one channel
  function automatic void debounce_and_repeat(input logic [31:0] t, input logic [2:0] ch,
                                              input logic [2:0] raw);
    key_word_t   found [$];
    key_word_t   kw;
    logic [31:0] elapsed;
    logic [31:0] since_due;
    logic [7:0]  c;
    logic        pressed;
    logic        emit;
    int          k;
    for (int m = 0; m < MUX_COUNT_DEF; m++) begin
      k       = m * CHANNELS_PER_MUX_DEF + ch;
      pressed = ~raw[m];
      c       = char_rows[m][8*ch +: 8];
      emit    = 1'b0;
      elapsed = t - changed_at[k];
      if (pressed != seen_pressed[k]) begin
        seen_pressed[k] = pressed;
        changed_at[k]   = t;
      end else if (elapsed >= {16'd0, debounce_cfg}) begin
        stable_now[k] = pressed;
      end
      // press edge schedules the first repeat, held key repeats on signed elapsed time
      if (!stable_prev[k] && stable_now[k]) begin
        if (c != 8'd0) begin
          emit      = 1'b1;
          due_at[k] = t + {16'd0, initial_cfg};
        end
      end else if (stable_now[k]) begin
        since_due = t - due_at[k];
        if (!since_due[31] && since_due >= {16'd0, interval_cfg} && c != 8'd0) begin
          emit      = 1'b1;
          due_at[k] = t;
        end
      end
      stable_prev[k] = stable_now[k];
      if (emit) begin
        kw.key_char    = c;
        kw.key_number  = k[KEYNUM_W-1:0];
        kw.last_of_run = 1'b0;
        found.push_back(kw);
      end
    end
    if (found.size() > 0) found[found.size()-1].last_of_run = 1'b1;
    foreach (found[i]) key_words_due.push_back(found[i]);
  endfunction

  // one scan word; valid stays high for a following word unless the sender idles
  task automatic send_scan(input logic [31:0] t, input logic [2:0] ch, input logic [2:0] raw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {2'b00, raw, ch, t};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    debounce_and_repeat(t, ch, raw);
    scans_sent++;
    @(negedge clk);
  endtask

  // wait for all key words, then for words still in the pipe that yield none
  task automatic wait_until_quiet();
    in_tvalid <= 1'b0;
    while (key_words_due.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DEBOUNCE:     debounce_cfg = value[15:0];
      REG_REP_INITIAL:  initial_cfg  = value[15:0];
      REG_REP_INTERVAL: interval_cfg = value[15:0];
      REG_MAP_MUX0:     char_rows[0] = value;
      REG_MAP_MUX1:     char_rows[1] = value;
      REG_MAP_MUX2:     char_rows[2] = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] init_ms,
                                input logic [15:0] intv, input logic [63:0] row0,
                                input logic [63:0] row1, input logic [63:0] row2,
                                input bit with_unmapped);
    wait_until_quiet();
    write_reg(REG_DEBOUNCE, {48'd0, deb});
    write_reg(REG_REP_INITIAL, {48'd0, init_ms});
    write_reg(REG_REP_INTERVAL, {48'd0, intv});
    write_reg(REG_MAP_MUX0, row0);
    write_reg(REG_MAP_MUX1, row1);
    write_reg(REG_MAP_MUX2, row2);
    if (with_unmapped) begin
      write_reg(UNMAPPED_IDX_LO, {$urandom(), $urandom()});
      write_reg(UNMAPPED_IDX_HI, {$urandom(), $urandom()});
    end
    cfg_valid <= 1'b0;
  endtask

  // eight character bytes, some of them zero
  function automatic logic [63:0] char_row();
    logic [63:0] row;
    for (int b = 0; b < 8; b++) begin
      case ($urandom_range(0, 7))
        0:       row[8*b +: 8] = 8'h00;
        1:       row[8*b +: 8] = 8'hFF;
        default: row[8*b +: 8] = 8'($urandom_range(1, 255));
      endcase
    end
    return row;
  endfunction

  // round-robin scan with held keys, occasional bounce and time jumps
  task automatic scan_keyboard(input int count, input int step_max);
    logic [2:0] held [8];
    logic [2:0] ch;
    logic [2:0] raw;
    int         roll;
    int         next_ch;
    next_ch = 0;
    for (int c = 0; c < 8; c++) held[c] = 3'b111;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) scan_ms = $urandom();
      else scan_ms = scan_ms + $urandom_range(0, step_max);
      if ($urandom_range(0, 9) == 0) begin
        ch = 3'($urandom_range(0, 7));
      end else begin
        ch      = 3'(next_ch);
        next_ch = (next_ch + 1) % 8;
      end
      if ($urandom_range(0, 11) == 0) held[ch] = held[ch] ^ 3'(1 << $urandom_range(0, 2));
      raw = held[ch];
      if (roll >= 94) raw = 3'($urandom_range(0, 7));
      send_scan(scan_ms, ch, raw);
    end
  endtask

  // reset registers: all maps zero, so held keys stay silent
  task automatic test_default_registers();
    send_scan(32'h0000_0000, 3'd0, 3'b111);
    send_scan(32'h0000_0010, 3'd0, 3'b000);
    send_scan(32'h0000_0030, 3'd0, 3'b000);
    send_scan(32'h0000_0400, 3'd0, 3'b000);
  endtask

  // zero delays: held samples repeat unless time goes backwards; covers time wrap and time going backwards
  task automatic test_zero_delays();
    apply_settings(16'd0, 16'd0, 16'd0, 64'hFF01_2345_6789_ABCD,
                   64'h8040_2010_0804_0201, 64'h7F3E_5D1C_2B4A_6958, 1'b1);
    send_scan(32'hFFFF_FFF0, 3'd7, 3'b000);
    send_scan(32'hFFFF_FFFA, 3'd7, 3'b000);
    send_scan(32'h0000_0004, 3'd7, 3'b000);
    send_scan(32'h0000_0002, 3'd7, 3'b000);
    send_scan(32'h0000_0009, 3'd7, 3'b101);
    send_scan(32'h0000_0009, 3'd0, 3'b111);
    send_scan(32'h0000_0009, 3'd0, 3'b010);
    send_scan(32'h0000_0009, 3'd0, 3'b010);
    send_scan(32'h0000_000A, 3'd0, 3'b111);
    send_scan(32'h0000_000B, 3'd0, 3'b111);
  endtask

  // zero map byte on mux 1 channel 2 and on mux 2 channel 3
  task automatic test_zero_map_byte();
    apply_settings(16'd5, 16'd10, 16'd3, 64'h4847_4645_4443_4241,
                   64'h5857_5655_5400_5251, 64'h6867_6665_0063_6261, 1'b0);
    send_scan(32'd100, 3'd2, 3'b000);
    send_scan(32'd103, 3'd2, 3'b000);
    send_scan(32'd120, 3'd2, 3'b000);
    send_scan(32'd130, 3'd3, 3'b000);
    send_scan(32'd140, 3'd3, 3'b100);
    send_scan(32'd150, 3'd2, 3'b111);
  endtask

  task automatic test_typical_typing();
    apply_settings(16'd20, 16'd200, 16'd50, char_row(), char_row(), char_row(), 1'b0);
    scan_keyboard(140, 12);
  endtask

  // longest debounce and repeat times with coarse time steps
  task automatic test_slowest_timing();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, char_row(), char_row(), char_row(), 1'b0);
    scan_keyboard(140, 20000);
  endtask

  task automatic test_mixed_settings();
    repeat (2) begin
      apply_settings(16'($urandom_range(0, 40)), 16'($urandom_range(0, 300)),
                     16'($urandom_range(0, 80)), char_row(), char_row(), char_row(), 1'b0);
      scan_keyboard(70, 10);
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_tvalid       <= 1'b0;
    in_tdata        <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_DEBOUNCE;
    cfg_data        <= '0;
    scan_ms          = 32'd1000;
    scans_sent       = 0;
    reg_writes       = 0;
    send_idle_pct    = 27;
    ready_stall_pct  = 68;
    reset_keys();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_registers();
    test_zero_delays();
    test_zero_map_byte();
    test_typical_typing();
    send_idle_pct   = 68;
    ready_stall_pct = 27;
    test_slowest_timing();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    test_mixed_settings();

    wait_until_quiet();
    $display("sent %0d scan words over %0d register writes, checked %0d key words",
             scans_sent, reg_writes, words_checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
